FILE: rtl/track_table_gated_merge_assert.svh
// Assertion macros for the track table
`ifndef TRACK_TABLE_GATED_MERGE_ASSERT_SVH
`define TRACK_TABLE_GATED_MERGE_ASSERT_SVH
// condition must hold at every edge out of reset
`define TT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the following cycle
`define TT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/ttgm_pkg.sv
// Shared types and constants of the track table
`default_nettype none
package ttgm_pkg;
  localparam int MAX_TRACKS = 32;
  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);

  localparam logic [1:0] REG_GATE = 2'd0;
  localparam logic [1:0] REG_TTL  = 2'd1;
  localparam logic [1:0] REG_KEEP = 2'd2;

  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [3:0]        obj_class;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic [7:0]        confidence_in;
    logic [15:0]       track_label;
    logic [15:0]       elapsed_ms;
  } in_t;

  typedef struct packed {
    logic              matched;
    logic              inserted;
    logic              dropped;
    logic [4:0]        slot_index;
    logic signed [15:0] smoothed_x;
    logic signed [15:0] smoothed_z;
    logic [5:0]        removed_count;
    logic [5:0]        live_count;
  } out_t;

  typedef struct packed {
    logic [3:0]        cls;
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic [7:0]        conf;
    logic [15:0]       ttl;
    logic [15:0]       label;
  } entry_t;

  typedef struct packed {
    logic square;
    logic compare;
    logic age;
    logic shift;
  } cell_ctrl_t;
endpackage
`default_nettype wire

FILE: rtl/ttgm_cell.sv
// One table slot: distance check, ageing and left shift for compaction
`default_nettype none
module ttgm_cell import ttgm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               live,
  input  wire logic [3:0]         det_cls,
  input  wire logic signed [15:0] det_x,
  input  wire logic signed [15:0] det_z,
  input  wire logic [31:0]        gate2,
  input  wire logic [15:0]        elapsed,
  input  wire logic               wr_en,
  input  wire entry_t             wr_data,
  input  wire entry_t             nb_entry,
  input  wire logic               nb_dead,
  input  wire logic               seen_in,
  input  wire logic               found_in,
  output entry_t                  entry_o,
  output logic                    dead_o,
  output logic                    seen_out,
  output logic                    found_out,
  output logic                    sel_o
);
  entry_t             e_r;
  logic               dead_r, hit_r;
  logic [31:0]        sqx_r, sqz_r;
  logic signed [16:0] dx, dz;
  logic signed [33:0] mx, mz;
  logic [32:0]        d2;
  logic [15:0]        t_age;

  always_comb begin
    dx = {e_r.x[15], e_r.x} - {det_x[15], det_x};
    dz = {e_r.z[15], e_r.z} - {det_z[15], det_z};
    mx = dx * dx;
    mz = dz * dz;
    d2 = {1'b0, sqx_r} + {1'b0, sqz_r};
    t_age = (e_r.ttl > elapsed) ? (e_r.ttl - elapsed) : 16'd0;
  end

  // inclusive: a cell at or after the first dead one pulls from its right neighbour
  assign seen_out  = seen_in | dead_r;
  assign found_out = found_in | hit_r;
  assign sel_o     = hit_r & ~found_in;
  assign entry_o   = e_r;
  assign dead_o    = dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      if (ctrl.age) dead_r <= live && (t_age == 16'd0);
      else if (ctrl.shift && seen_out) dead_r <= nb_dead;
      if (ctrl.compare)
        hit_r <= live && (e_r.cls == det_cls) && (d2 < {1'b0, gate2});
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) e_r <= wr_data;
    else if (ctrl.age) e_r.ttl <= t_age;
    else if (ctrl.shift && seen_out) e_r <= nb_entry;
    if (ctrl.square) begin
      sqx_r <= mx[31:0];
      sqz_r <= mz[31:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/track_table_gated_merge.sv
// Track table top level: controller, shared blend unit and the row of slot cells
// A detection of a known class that merges passes through distance squares, gate
// compare, first-match select with blend products, write back and output load;
// one that is appended or dropped is written or dropped in the select step and
// goes on to output load without the write back. An unknown class goes from
// acceptance straight to output load. A tick ages every entry; then compaction
// shifts the row left by one slot per cycle until no dead entry is left. Results
// wait in the output register, and the controller holds until that register is
// free. The next item is accepted the cycle after the result is loaded, once the
// controller is back in idle, so items are handled one at a time.
`default_nettype none
module track_table_gated_merge import ttgm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_DSQ, ST_DCMP, ST_DSEL, ST_DBL, ST_TAGE, ST_TSH, ST_DONE
  } state_t;

  state_t          state_r;
  in_t             item_r;
  out_t            res_r, out_r;
  logic            out_valid_r;
  logic [15:0]     gate_r, ttl_r;
  logic [8:0]      keep_r;
  logic [31:0]     gate2_r;
  logic [CNT_W-1:0] count_r;
  logic [5:0]      removed_r;
  logic [IDX_W-1:0] widx_r;
  logic signed [26:0] kx_r, ix_r, kz_r, iz_r;
  logic [7:0]      conf_r;

  cell_ctrl_t      ctrl;
  entry_t          ent_w  [MAX_TRACKS];
  logic            dead_w [MAX_TRACKS];
  logic [MAX_TRACKS:0] seen_c, found_c;
  logic [MAX_TRACKS-1:0] sel_v, wr_v;
  entry_t          wr_data, sel_ent;
  logic [IDX_W-1:0] sel_idx;
  logic [8:0]      k_sat, k_inv;
  logic signed [26:0] bx, bz;

  assign seen_c[0]  = 1'b0;
  assign found_c[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_TRACKS; g++) begin : g_cell
      entry_t nb_e;
      logic   nb_d;
      if (g == MAX_TRACKS - 1) begin : g_last
        assign nb_e = '0;
        assign nb_d = 1'b0;
      end else begin : g_mid
        assign nb_e = ent_w[g+1];
        assign nb_d = dead_w[g+1];
      end
      ttgm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
        .live(count_r > CNT_W'(g)),
        .det_cls(item_r.obj_class), .det_x(item_r.pos_x), .det_z(item_r.pos_z),
        .gate2(gate2_r), .elapsed(item_r.elapsed_ms),
        .wr_en(wr_v[g]), .wr_data(wr_data),
        .nb_entry(nb_e), .nb_dead(nb_d),
        .seen_in(seen_c[g]), .found_in(found_c[g]),
        .entry_o(ent_w[g]), .dead_o(dead_w[g]),
        .seen_out(seen_c[g+1]), .found_out(found_c[g+1]), .sel_o(sel_v[g])
      );
    end
  endgenerate

  always_comb begin
    sel_ent = '0;
    sel_idx = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (sel_v[i]) begin
        sel_ent = sel_ent | ent_w[i];
        sel_idx = sel_idx | IDX_W'(i);
      end
    end
  end

  assign k_sat = (keep_r > 9'd256) ? 9'd256 : keep_r;
  assign k_inv = 9'd256 - k_sat;
  assign bx = kx_r + ix_r + 27'sd128;
  assign bz = kz_r + iz_r + 27'sd128;

  always_comb begin
    ctrl = '0;
    wr_v = '0;
    wr_data = '0;
    case (state_r)
      ST_DSQ:  ctrl.square  = 1'b1;
      ST_DCMP: ctrl.compare = 1'b1;
      ST_TAGE: ctrl.age     = 1'b1;
      ST_TSH:  ctrl.shift   = seen_c[MAX_TRACKS];
      ST_DSEL: begin
        wr_data.cls   = item_r.obj_class;
        wr_data.x     = item_r.pos_x;
        wr_data.z     = item_r.pos_z;
        wr_data.conf  = item_r.confidence_in;
        wr_data.ttl   = ttl_r;
        wr_data.label = item_r.track_label;
        if (!found_c[MAX_TRACKS] && count_r < CNT_W'(MAX_TRACKS)) begin
          for (int i = 0; i < MAX_TRACKS; i++)
            wr_v[i] = (count_r == CNT_W'(i));
        end
      end
      ST_DBL: begin
        wr_data       = ent_w[widx_r];
        wr_data.x     = bx[23:8];
        wr_data.z     = bz[23:8];
        wr_data.conf  = conf_r;
        wr_data.ttl   = ttl_r;
        for (int i = 0; i < MAX_TRACKS; i++)
          wr_v[i] = (widx_r == IDX_W'(i));
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      gate_r      <= 16'd1280;
      ttl_r       <= 16'd1500;
      keep_r      <= 9'd77;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GATE: gate_r <= cfg_wdata;
          REG_TTL:  ttl_r  <= cfg_wdata;
          REG_KEEP: keep_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            res_r <= '0;
            removed_r <= '0;
            if (in_data.opcode == OP_TICK) state_r <= ST_TAGE;
            else if (in_data.obj_class == 4'd0) state_r <= ST_DONE;
            else state_r <= ST_DSQ;
          end
        end
        ST_DSQ:  state_r <= ST_DCMP;
        ST_DCMP: state_r <= ST_DSEL;
        ST_DSEL: begin
          if (found_c[MAX_TRACKS]) begin
            state_r <= ST_DBL;
          end else begin
            if (count_r < CNT_W'(MAX_TRACKS)) begin
              res_r.inserted   <= 1'b1;
              res_r.slot_index <= 5'(count_r);
              res_r.smoothed_x <= item_r.pos_x;
              res_r.smoothed_z <= item_r.pos_z;
              count_r <= count_r + 1'b1;
            end else begin
              res_r.dropped <= 1'b1;
            end
            state_r <= ST_DONE;
          end
        end
        ST_DBL: begin
          res_r.matched    <= 1'b1;
          res_r.slot_index <= 5'(widx_r);
          res_r.smoothed_x <= bx[23:8];
          res_r.smoothed_z <= bz[23:8];
          state_r <= ST_DONE;
        end
        ST_TAGE: state_r <= ST_TSH;
        ST_TSH: begin
          if (seen_c[MAX_TRACKS]) begin
            count_r   <= count_r - 1'b1;
            removed_r <= removed_r + 6'd1;
          end else begin
            res_r.removed_count <= removed_r;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            // live count sits in the low bits of the result
            out_r <= {res_r[$bits(out_t)-1:6], 6'(count_r)};
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gate2_r <= gate_r * gate_r;
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == ST_DSEL) begin
      widx_r <= sel_idx;
      conf_r <= item_r.confidence_in;
      kx_r <= $signed({18'd0, k_sat}) * 27'(sel_ent.x);
      kz_r <= $signed({18'd0, k_sat}) * 27'(sel_ent.z);
      ix_r <= $signed({18'd0, k_inv}) * 27'(item_r.pos_x);
      iz_r <= $signed({18'd0, k_inv}) * 27'(item_r.pos_z);
    end
  end

`include "track_table_gated_merge_assert.svh"
  `TT_ASSERT_ALWAYS(a_count_max, count_r <= CNT_W'(MAX_TRACKS), "entry count above table size")
  `TT_ASSERT_ALWAYS(a_sel_onehot, $onehot0(sel_v), "more than one slot selected")
  `TT_ASSERT_ALWAYS(a_flags, !out_valid_r || $onehot0({out_r.matched, out_r.inserted, out_r.dropped}), "flag clash")
  `TT_ASSERT_NEXT(a_tick_age, in_valid && in_ready && in_data.opcode == OP_TICK, state_r == ST_TAGE, "tick not aged")
endmodule
`default_nettype wire

FILE: dv/track_table_gated_merge_tb.sv
// Self-checking testbench for the gated track table: directed and random items
`timescale 1ns / 100ps
`default_nettype none
module track_table_gated_merge_tb;
  import ttgm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GATE;
  logic [15:0] cfg_wdata = '0;

  track_table_gated_merge dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [15:0] gate_r, ttl_r;
  logic [8:0]  keep_r;
  int          n_live;
  entry_t      tbl[MAX_TRACKS];

  in_t  pending_items[$];
  out_t expected_results[$];
  int   n_errors = 0;
  int   idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_errors++;
  endtask

  function automatic void enqueue(input in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic in_t rand_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return in_t'(raw[$bits(in_t)-1:0]);
  endfunction

  function automatic logic signed [15:0] blend_pos(input logic signed [15:0] old_p,
                                                   input logic signed [15:0] new_p,
                                                   input int k);
    longint s;
    s = longint'(k) * old_p + longint'(256 - k) * new_p + 128;
    return 16'(s >>> 8);
  endfunction

  function automatic out_t predict_item(input in_t it);
    out_t r;
    int w, k;
    longint dx, dz, g2;
    logic [15:0] t;
    bit found;
    r = '0;
    if (it.opcode == OP_TICK) begin
      w = 0;
      for (int i = 0; i < n_live; i++) begin
        t = (tbl[i].ttl > it.elapsed_ms) ? tbl[i].ttl - it.elapsed_ms : 16'd0;
        if (t == 0) begin
          r.removed_count++;
        end else begin
          tbl[w] = tbl[i];
          tbl[w].ttl = t;
          w++;
        end
      end
      n_live = w;
    end else if (it.obj_class != 0) begin
      g2 = longint'(gate_r) * gate_r;
      k = (keep_r > 256) ? 256 : keep_r;
      found = 1'b0;
      for (int i = 0; i < n_live && !found; i++) begin
        dx = longint'(tbl[i].x) - it.pos_x;
        dz = longint'(tbl[i].z) - it.pos_z;
        if (tbl[i].cls == it.obj_class && dx * dx + dz * dz < g2) begin
          tbl[i].x = blend_pos(tbl[i].x, it.pos_x, k);
          tbl[i].z = blend_pos(tbl[i].z, it.pos_z, k);
          tbl[i].conf = it.confidence_in;
          tbl[i].ttl = ttl_r;
          r.matched = 1'b1;
          r.slot_index = 5'(i);
          r.smoothed_x = tbl[i].x;
          r.smoothed_z = tbl[i].z;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (n_live < MAX_TRACKS) begin
          tbl[n_live] = '{cls: it.obj_class, x: it.pos_x, z: it.pos_z,
                          conf: it.confidence_in, ttl: ttl_r, label: it.track_label};
          r.inserted = 1'b1;
          r.slot_index = 5'(n_live);
          r.smoothed_x = it.pos_x;
          r.smoothed_z = it.pos_z;
          n_live++;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end
    r.live_count = 6'(n_live);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_item(in_data));
        in_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_data.matched !== e.matched)
            report_mismatch("matched", out_data.matched, e.matched);
          if (out_data.inserted !== e.inserted)
            report_mismatch("inserted", out_data.inserted, e.inserted);
          if (out_data.dropped !== e.dropped)
            report_mismatch("dropped", out_data.dropped, e.dropped);
          if (out_data.slot_index !== e.slot_index)
            report_mismatch("slot_index", out_data.slot_index, e.slot_index);
          if (out_data.smoothed_x !== e.smoothed_x)
            report_mismatch("smoothed_x", out_data.smoothed_x, e.smoothed_x);
          if (out_data.smoothed_z !== e.smoothed_z)
            report_mismatch("smoothed_z", out_data.smoothed_z, e.smoothed_z);
          if (out_data.removed_count !== e.removed_count)
            report_mismatch("removed_count", out_data.removed_count, e.removed_count);
          if (out_data.live_count !== e.live_count)
            report_mismatch("live_count", out_data.live_count, e.live_count);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("[track_table_gated_merge] ERROR");
      $finish;
    end
  end

  function automatic in_t make_detect(input logic [3:0] c, input logic [15:0] x,
                                      input logic [15:0] z);
    in_t it;
    it = '0;
    it.opcode = OP_DETECT;
    it.obj_class = c;
    it.pos_x = x;
    it.pos_z = z;
    it.confidence_in = 8'($urandom);
    it.track_label = 16'($urandom);
    it.elapsed_ms = 16'($urandom);
    return it;
  endfunction

  function automatic in_t make_tick(input logic [15:0] ms);
    in_t it;
    it = rand_item();
    it.opcode = OP_TICK;
    it.elapsed_ms = ms;
    return it;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GATE: gate_r = v;
      REG_TTL:  ttl_r = v;
      default:  keep_r = v[8:0];
    endcase
  endtask

  // settle all outstanding items; the idle state must still hold after a wait on the
  // clock so that an item popped in the same step is not missed
  task automatic drain();
    forever begin
      wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
      repeat (2) @(posedge clk);
      if (pending_items.size() == 0 && !in_valid && expected_results.size() == 0)
        break;
    end
  endtask

  // near-cluster random detections with some noise, plus ticks and fully random items
  task automatic random_phase(input int n);
    in_t it;
    logic [15:0] cx, cz;
    cx = 16'($urandom);
    cz = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    it = make_tick($urandom_range(0, 9) == 0 ? 16'($urandom)
                                : 16'($urandom_range(0, 800)));
        2:       it = rand_item();
        default: it = make_detect(4'($urandom_range(0, 4)),
                                  cx + 16'($urandom_range(0, 2047)) - 16'd1024,
                                  cz + 16'($urandom_range(0, 2047)) - 16'd1024);
      endcase
      enqueue(it);
    end
  endtask

  initial begin
    gate_r = 16'd1280;
    ttl_r = 16'd1500;
    keep_r = 9'd77;
    n_live = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, unknown class, gate edge, fill to full, drops
    enqueue(make_detect(4'd0, 16'h7fff, 16'h8000));
    enqueue(make_detect(4'd15, 16'h7fff, 16'h7fff));
    enqueue(make_detect(4'd15, 16'h7fff, 16'h7fff));
    enqueue(make_detect(4'd15, 16'h8000, 16'h8000));
    enqueue(make_detect(4'd1, 16'd0, 16'd0));
    enqueue(make_detect(4'd1, 16'd1280, 16'd0));
    enqueue(make_detect(4'd1, 16'd1279, 16'd0));
    for (int i = 0; i < 30; i++)
      enqueue(make_detect(4'd2, 16'(i * 2000), 16'hffff));
    enqueue(make_tick(16'd0));
    enqueue(make_tick(16'd1499));
    enqueue(make_tick(16'hffff));
    drain();

    write_reg(REG_GATE, 16'hffff);
    write_reg(REG_TTL, 16'hffff);
    write_reg(REG_KEEP, 16'd256);
    random_phase(150);
    drain();
    write_reg(REG_KEEP, 16'h01ff);
    write_reg(REG_GATE, 16'd0);
    write_reg(REG_TTL, 16'd0);
    enqueue(make_detect(4'd3, 16'd5, 16'd5));
    enqueue(make_tick(16'd0));
    random_phase(100);
    drain();
    write_reg(REG_KEEP, 16'd0);
    write_reg(REG_TTL, 16'd1);
    random_phase(150);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_GATE, 16'($urandom_range(0, 4000)));
      write_reg(REG_TTL, 16'($urandom_range(1, 3000)));
      write_reg(REG_KEEP, 16'($urandom_range(0, 300)));
      random_phase(150);
      drain();
    end

    if (n_errors == 0) $display("[track_table_gated_merge] OK");
    else $display("[track_table_gated_merge] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
